// ----- src/lpfp_pkg.sv -----
// Length-prefixed frame parser: shared types and constants.
// No dependencies.
package lpfp_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

    localparam logic [7:0] START_BYTE_RESET = 8'hFF;

    localparam logic [1:0] PHASE_HUNT    = 2'd0;
    localparam logic [1:0] PHASE_HEADER  = 2'd1;
    localparam logic [1:0] PHASE_PAYLOAD = 2'd2;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  version;
        logic [15:0] payload_length;
        logic [15:0] vendor_id;
        logic [15:0] command_word;
        logic [7:0]  data_byte;
        logic        last_of_frame;
    } result_t;

endpackage

// ----- src/lpfp_if.sv -----
// Valid/ready channel interfaces for the frame parser: received bytes in,
// parse results out. Depends on nothing.
interface lpfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfp_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  version;
    logic [15:0] payload_length;
    logic [15:0] vendor_id;
    logic [15:0] command_word;
    logic [7:0]  data_byte;
    logic        last_of_frame;

    modport source (
        output valid, output result_kind, output version, output payload_length,
        output vendor_id, output command_word, output data_byte, output last_of_frame,
        input ready
    );
    modport sink (
        input valid, input result_kind, input version, input payload_length,
        input vendor_id, input command_word, input data_byte, input last_of_frame,
        output ready
    );
endinterface

// ----- src/lpfp_parser.sv -----
// Frame parser state machine: hunt, header gather, payload count.
// One byte per step_en; depends on lpfp_pkg.
module lpfp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           start_byte,
    input  logic                 step_en,
    input  logic [7:0]           rx_byte,
    output logic                 res_valid,
    output lpfp_pkg::result_t    res
);

    localparam int unsigned IW = lpfp_pkg::HDR_IDX_W;

    logic [1:0]    phase_reg,   phase_next;
    logic [IW-1:0] hdr_idx_reg, hdr_idx_next;
    logic [7:0]    version_reg, version_next;
    logic [15:0]   length_reg,  length_next;
    logic [15:0]   vendor_reg,  vendor_next;
    logic [15:0]   command_reg, command_next;
    logic [15:0]   remain_reg,  remain_next;

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        version_next = version_reg;
        length_next  = length_reg;
        vendor_next  = vendor_reg;
        command_next = command_reg;
        remain_next  = remain_reg;
        res_valid    = 1'b0;
        res          = '0;

        case (phase_reg)
            lpfp_pkg::PHASE_HEADER:
            begin
                case (hdr_idx_reg)
                    IW'(1):  version_next = rx_byte;
                    IW'(2):  length_next  = {rx_byte, length_reg[7:0]};
                    IW'(3):  length_next  = {length_reg[15:8], rx_byte};
                    IW'(4):  vendor_next  = {rx_byte, vendor_reg[7:0]};
                    IW'(5):  vendor_next  = {vendor_reg[15:8], rx_byte};
                    IW'(6):  command_next = {rx_byte, command_reg[7:0]};
                    default: command_next = {command_reg[15:8], rx_byte};
                endcase
                if (hdr_idx_reg >= IW'(1) && hdr_idx_reg < IW'(lpfp_pkg::HEADER_BYTES - 1))
                begin
                    hdr_idx_next = hdr_idx_reg + IW'(1);
                end
                else
                begin
                    hdr_idx_next = '0;
                    res_valid    = 1'b1;
                    res.result_kind = lpfp_pkg::KIND_HEADER;
                    if (length_next == 16'd0)
                    begin
                        phase_next        = lpfp_pkg::PHASE_HUNT;
                        res.last_of_frame = 1'b1;
                    end
                    else
                    begin
                        phase_next  = lpfp_pkg::PHASE_PAYLOAD;
                        remain_next = length_next;
                    end
                end
            end
            lpfp_pkg::PHASE_PAYLOAD:
            begin
                if (remain_reg != 16'd0)
                begin
                    remain_next = remain_reg - 16'd1;
                end
                res_valid         = 1'b1;
                res.result_kind   = lpfp_pkg::KIND_PAYLOAD;
                res.data_byte     = rx_byte;
                res.last_of_frame = (remain_next == 16'd0);
                if (remain_next == 16'd0)
                begin
                    phase_next = lpfp_pkg::PHASE_HUNT;
                end
            end
            default:
            begin
                phase_next = lpfp_pkg::PHASE_HUNT;
                if (rx_byte == start_byte)
                begin
                    phase_next   = lpfp_pkg::PHASE_HEADER;
                    hdr_idx_next = IW'(1);
                    version_next = '0;
                    length_next  = '0;
                    vendor_next  = '0;
                    command_next = '0;
                end
            end
        endcase

        res.version        = version_next;
        res.payload_length = length_next;
        res.vendor_id      = vendor_next;
        res.command_word   = command_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= lpfp_pkg::PHASE_HUNT;
            hdr_idx_reg <= '0;
            version_reg <= '0;
            length_reg  <= '0;
            vendor_reg  <= '0;
            command_reg <= '0;
            remain_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            version_reg <= version_next;
            length_reg  <= length_next;
            vendor_reg  <= vendor_next;
            command_reg <= command_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

// ----- src/length_prefixed_frame_parser.sv -----
// Length-prefixed frame parser, top level: input byte register, parser,
// two-entry result queue. Depends on lpfp_pkg, lpfp_if, lpfp_parser.
//
// Takes one received byte per cycle while the output queue can take a result,
// with no bubbles between frames. A byte that is taken is held in the input
// register and parsed from there; its result (if any) is written into a
// two-entry output queue when the parser steps, so a result reaches the
// output through the input register and then the queue. Header results carry
// the full header, payload results carry one byte plus the header fields; the
// final result of a frame has last_of_frame set. Bytes ahead of the start
// byte produce no result. The input stalls only when both queue entries are
// full and the output is not ready. start_byte is written through
// cfg_we/cfg_wdata and resets to 0xFF.
module length_prefixed_frame_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    lpfp_rx_if.sink          rx,
    lpfp_res_if.source       res
);

    logic [7:0]        start_byte_reg;
    logic              stage_valid_reg;
    logic [7:0]        stage_byte_reg;
    logic [1:0]        count_reg;
    lpfp_pkg::result_t q0_reg;
    lpfp_pkg::result_t q1_reg;

    logic              stage_go;
    logic              step;
    logic              push;
    logic              pop;
    logic              parse_valid;
    lpfp_pkg::result_t parse_res;

    assign pop      = res.valid && res.ready;
    assign stage_go = (count_reg != 2'd2) || res.ready;
    assign step     = stage_valid_reg && stage_go;
    assign push     = step && parse_valid;
    assign rx.ready = !stage_valid_reg || stage_go;

    lpfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_byte (start_byte_reg),
        .step_en    (step),
        .rx_byte    (stage_byte_reg),
        .res_valid  (parse_valid),
        .res        (parse_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= lpfp_pkg::START_BYTE_RESET;
        end
        else if (cfg_we)
        begin
            start_byte_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            stage_byte_reg <= rx.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        case ({push, pop})
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    q0_reg <= parse_res;
                end
                else
                begin
                    q0_reg <= q1_reg;
                    q1_reg <= parse_res;
                end
            end
            2'b01:
            begin
                q0_reg <= q1_reg;
            end
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    q0_reg <= parse_res;
                end
                else
                begin
                    q1_reg <= parse_res;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid          = (count_reg != 2'd0);
    assign res.result_kind    = q0_reg.result_kind;
    assign res.version        = q0_reg.version;
    assign res.payload_length = q0_reg.payload_length;
    assign res.vendor_id      = q0_reg.vendor_id;
    assign res.command_word   = q0_reg.command_word;
    assign res.data_byte      = q0_reg.data_byte;
    assign res.last_of_frame  = q0_reg.last_of_frame;

endmodule

// ----- src/lpfp_checker.sv -----
// Port-level assertions for the frame parser, bound to the top level.
// Depends on lpfp_pkg and length_prefixed_frame_parser.
module lpfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        result_kind,
    input logic [15:0] payload_length,
    input logic [7:0]  data_byte,
    input logic        last_of_frame
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_kind)
            && $stable(data_byte) && $stable(payload_length) && $stable(last_of_frame))
        else $error("result changed while stalled");

    a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == lpfp_pkg::KIND_HEADER
            |-> last_of_frame == (payload_length == 16'd0))
        else $error("header last flag does not match length");

    a_hdr_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == lpfp_pkg::KIND_HEADER |-> data_byte == 8'd0)
        else $error("header result carries data");

    a_pay_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == lpfp_pkg::KIND_PAYLOAD |-> payload_length != 16'd0)
        else $error("payload result in a zero-length frame");

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .result_kind    (res.result_kind),
    .payload_length (res.payload_length),
    .data_byte      (res.data_byte),
    .last_of_frame  (res.last_of_frame)
);
